>>> src/smfe_pkg.sv
// Shared types and constants for the stack machine floating-point evaluator.
`default_nettype none

package smfe_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] OP_HALT      = 8'd0;
	localparam logic [7:0] OP_PUSH      = 8'd1;
	localparam logic [7:0] OP_ADD       = 8'd2;
	localparam logic [7:0] OP_SUB       = 8'd3;
	localparam logic [7:0] OP_MUL       = 8'd4;
	localparam logic [7:0] OP_DIV       = 8'd5;
	localparam logic [7:0] OP_EMIT_NUM  = 8'd6;
	localparam logic [7:0] OP_EMIT_MSG  = 8'd7;

	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_NUMBER  = 3'd1,
		KIND_MESSAGE = 3'd2,
		KIND_HALTED  = 3'd3,
		KIND_FAULT   = 3'd4,
		KIND_IGNORED = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CLS_HALT,
		CLS_PUSH,
		CLS_ARITH,
		CLS_PRINT_NUM,
		CLS_PRINT_MSG,
		CLS_BAD
	} cls_t;

	typedef enum logic [1:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_DIV
	} fop_t;

	typedef struct packed {
		cls_t        cls;
		fop_t        fop;
		logic [7:0]  opcode;
		logic [7:0]  msg;
		logic [63:0] value;
	} cmd_t;

	typedef struct packed {
		logic start;
		fop_t op;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} fpu_rsp_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_NORM,
		F_ALIGN,
		F_ADDSUB,
		F_POSTNORM,
		F_MUL,
		F_DIV,
		F_RND_SHIFT,
		F_RND_PACK,
		F_DONE
	} fpu_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PRINT_RD,
		B_POP_A,
		B_CAP_A,
		B_EXEC,
		B_WAIT
	} back_state_t;

endpackage

`default_nettype wire

>>> src/smfe_front.sv
// Front end: accepts requests, decodes the opcode and queues the commands.
`default_nettype none

module smfe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    opcode,
	input  wire logic [7:0]    message_index,
	input  wire logic [63:0]   constant_bits,
	output logic               cmd_valid,
	output smfe_pkg::cmd_t     cmd,
	input  wire logic          cmd_pop
);
	import smfe_pkg::*;

	cmd_t       queue_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	cmd_t       decoded;

	always_comb begin
		decoded.opcode = opcode;
		decoded.msg    = message_index;
		decoded.value  = constant_bits;
		decoded.fop    = FOP_ADD;
		case (opcode)
			OP_HALT:      decoded.cls = CLS_HALT;
			OP_PUSH:      decoded.cls = CLS_PUSH;
			OP_ADD:       decoded.cls = CLS_ARITH;
			OP_SUB: begin
				decoded.cls = CLS_ARITH;
				decoded.fop = FOP_SUB;
			end
			OP_MUL: begin
				decoded.cls = CLS_ARITH;
				decoded.fop = FOP_MUL;
			end
			OP_DIV: begin
				decoded.cls = CLS_ARITH;
				decoded.fop = FOP_DIV;
			end
			OP_EMIT_NUM:  decoded.cls = CLS_PRINT_NUM;
			OP_EMIT_MSG:  decoded.cls = CLS_PRINT_MSG;
			default:      decoded.cls = CLS_BAD;
		endcase
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/smfe_fpu.sv
// Multi-cycle double precision add, subtract, multiply and divide unit.
`default_nettype none

module smfe_fpu (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  smfe_pkg::fpu_req_t  req,
	input  wire logic [63:0]    a_bits,
	input  wire logic [63:0]    b_bits,
	output smfe_pkg::fpu_rsp_t  rsp
);
	import smfe_pkg::*;

	localparam logic signed [12:0] BIAS      = 13'sd1023;
	localparam logic signed [12:0] EMIN      = -13'sd1022;
	localparam logic signed [12:0] EXP_LIMIT = 13'sd2047;
	localparam logic [62:0]        INF_MAG   = {11'h7FF, 52'b0};

	fpu_state_t        state_q, state_d;
	fop_t              op_q;
	logic              sa_q, sb_q, s_q, eff_sub_q, den_q;
	logic signed [12:0] ea_q, eb_q, e_q;
	logic [52:0]       ma_q, mb_q;
	logic [55:0]       x_q, y_q, r_q;
	logic [5:0]        cnt_q;
	logic [53:0]       prod_q;
	logic [1:0]        psh_q;
	logic [105:0]      acc_q;
	logic [53:0]       rem_q;
	logic [54:0]       quo_q;
	logic [63:0]       res_q;

	// operand classification
	logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sb_eff, s_mul;
	logic              spec;
	logic [63:0]       spec_res;

	always_comb begin
		nan_a  = (&a_bits[62:52]) && (|a_bits[51:0]);
		nan_b  = (&b_bits[62:52]) && (|b_bits[51:0]);
		inf_a  = (&a_bits[62:52]) && !(|a_bits[51:0]);
		inf_b  = (&b_bits[62:52]) && !(|b_bits[51:0]);
		zero_a = !(|a_bits[62:0]);
		zero_b = !(|b_bits[62:0]);
		sb_eff = b_bits[63] ^ (req.op == FOP_SUB);
		s_mul  = a_bits[63] ^ b_bits[63];
		spec     = 1'b1;
		spec_res = CANON_NAN;
		case (req.op)
			FOP_ADD, FOP_SUB: begin
				if (nan_a || nan_b) begin
					spec_res = CANON_NAN;
				end else if (inf_a && inf_b) begin
					spec_res = (a_bits[63] == sb_eff) ? {a_bits[63], INF_MAG} : CANON_NAN;
				end else if (inf_a) begin
					spec_res = {a_bits[63], INF_MAG};
				end else if (inf_b) begin
					spec_res = {sb_eff, INF_MAG};
				end else if (zero_a && zero_b) begin
					spec_res = {a_bits[63] & sb_eff, 63'b0};
				end else if (zero_a) begin
					spec_res = {sb_eff, b_bits[62:0]};
				end else if (zero_b) begin
					spec_res = a_bits;
				end else begin
					spec = 1'b0;
				end
			end
			FOP_MUL: begin
				if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
					spec_res = CANON_NAN;
				end else if (inf_a || inf_b) begin
					spec_res = {s_mul, INF_MAG};
				end else if (zero_a || zero_b) begin
					spec_res = {s_mul, 63'b0};
				end else begin
					spec = 1'b0;
				end
			end
			default: begin
				if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
					spec_res = CANON_NAN;
				end else if (inf_a || zero_b) begin
					spec_res = {s_mul, INF_MAG};
				end else if (zero_a || inf_b) begin
					spec_res = {s_mul, 63'b0};
				end else begin
					spec = 1'b0;
				end
			end
		endcase
	end

	// addition: alignment
	logic              swap;
	logic signed [12:0] diff;
	logic [52:0]       mx, my;
	logic [111:0]      al_wide;
	logic [55:0]       y_al;

	always_comb begin
		swap    = (eb_q > ea_q) || ((eb_q == ea_q) && (mb_q > ma_q));
		mx      = swap ? mb_q : ma_q;
		my      = swap ? ma_q : mb_q;
		diff    = swap ? (eb_q - ea_q) : (ea_q - eb_q);
		al_wide = {my, 3'b0, 56'b0} >> diff[5:0];
		if (diff > 13'sd55) begin
			y_al = 56'd1;
		end else begin
			y_al = {al_wide[111:57], al_wide[56] | (|al_wide[55:0])};
		end
	end

	logic [56:0] sum;
	assign sum = eff_sub_q ? ({1'b0, x_q} - {1'b0, y_q}) : ({1'b0, x_q} + {1'b0, y_q});

	// multiplication: four 27x27 partial products
	logic [26:0]  mul_ah, mul_bh;
	logic [6:0]   pp_sh;
	logic [105:0] acc_next;

	always_comb begin
		mul_ah = cnt_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		mul_bh = cnt_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		case (psh_q)
			2'd0:    pp_sh = 7'd0;
			2'd1:    pp_sh = 7'd27;
			default: pp_sh = 7'd54;
		endcase
		acc_next = acc_q + ({52'b0, prod_q} << pp_sh);
	end

	// division: one quotient bit per cycle
	logic        q_bit;
	logic [53:0] rem_next;
	logic [54:0] quo_next;

	always_comb begin
		q_bit    = (rem_q >= {1'b0, mb_q});
		rem_next = (q_bit ? (rem_q - {1'b0, mb_q}) : rem_q) << 1;
		quo_next = {quo_q[53:0], q_bit};
	end

	// rounding
	logic signed [12:0] shd;
	logic [5:0]        sh6;
	logic [119:0]      dn_wide;
	logic              inc;
	logic [53:0]       mant;
	logic signed [12:0] ebias;
	logic [63:0]       packed_res;

	always_comb begin
		shd     = EMIN - e_q;
		sh6     = (shd > 13'sd63) ? 6'd63 : shd[5:0];
		dn_wide = {r_q, 64'b0} >> sh6;
		inc     = r_q[2] && (r_q[1] || r_q[0] || r_q[3]);
		mant    = {1'b0, r_q[55:3]} + {53'b0, inc};
		ebias   = e_q + BIAS + (mant[53] ? 13'sd1 : 13'sd0);
		if (den_q) begin
			packed_res = {s_q, 10'b0, mant[52], mant[51:0]};
		end else if (ebias >= EXP_LIMIT) begin
			packed_res = {s_q, INF_MAG};
		end else begin
			packed_res = {s_q, ebias[10:0], mant[53] ? mant[52:1] : mant[51:0]};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					state_d = spec ? F_DONE : F_NORM;
				end
			end
			F_NORM: begin
				if (ma_q[52] && mb_q[52]) begin
					case (op_q)
						FOP_ADD, FOP_SUB: state_d = F_ALIGN;
						FOP_MUL:          state_d = F_MUL;
						default:          state_d = F_DIV;
					endcase
				end
			end
			F_ALIGN:  state_d = F_ADDSUB;
			F_ADDSUB: begin
				if (sum == 57'd0) begin
					state_d = F_DONE;
				end else if (sum[56]) begin
					state_d = F_RND_SHIFT;
				end else begin
					state_d = F_POSTNORM;
				end
			end
			F_POSTNORM: begin
				if (r_q[55]) begin
					state_d = F_RND_SHIFT;
				end
			end
			F_MUL: begin
				if (cnt_q == 6'd4) begin
					state_d = F_RND_SHIFT;
				end
			end
			F_DIV: begin
				if (cnt_q == 6'd54) begin
					state_d = F_RND_SHIFT;
				end
			end
			F_RND_SHIFT: state_d = F_RND_PACK;
			F_RND_PACK:  state_d = F_DONE;
			F_DONE:      state_d = F_IDLE;
			default:     state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				op_q  <= req.op;
				sa_q  <= a_bits[63];
				sb_q  <= sb_eff;
				s_q   <= s_mul;
				res_q <= spec_res;
				ma_q  <= {|a_bits[62:52], a_bits[51:0]};
				mb_q  <= {|b_bits[62:52], b_bits[51:0]};
				ea_q  <= (|a_bits[62:52]) ? ($signed({2'b00, a_bits[62:52]}) - BIAS) : EMIN;
				eb_q  <= (|b_bits[62:52]) ? ($signed({2'b00, b_bits[62:52]}) - BIAS) : EMIN;
			end
			F_NORM: begin
				if (!ma_q[52]) begin
					if (ma_q[52:37] == 16'd0) begin
						ma_q <= ma_q << 16;
						ea_q <= ea_q - 13'sd16;
					end else begin
						ma_q <= ma_q << 1;
						ea_q <= ea_q - 13'sd1;
					end
				end
				if (!mb_q[52]) begin
					if (mb_q[52:37] == 16'd0) begin
						mb_q <= mb_q << 16;
						eb_q <= eb_q - 13'sd16;
					end else begin
						mb_q <= mb_q << 1;
						eb_q <= eb_q - 13'sd1;
					end
				end
				cnt_q <= 6'd0;
				acc_q <= '0;
				quo_q <= '0;
				// Pre-scale the dividend so the first quotient bit is the hidden one.
				if (ma_q < mb_q) begin
					rem_q <= {ma_q, 1'b0};
					e_q   <= ea_q - eb_q - 13'sd1;
				end else begin
					rem_q <= {1'b0, ma_q};
					e_q   <= (op_q == FOP_MUL) ? (ea_q + eb_q) : (ea_q - eb_q);
				end
				if (op_q == FOP_MUL) begin
					e_q <= ea_q + eb_q;
				end
			end
			F_ALIGN: begin
				x_q       <= {mx, 3'b0};
				y_q       <= y_al;
				e_q       <= swap ? eb_q : ea_q;
				s_q       <= swap ? sb_q : sa_q;
				eff_sub_q <= sa_q ^ sb_q;
			end
			F_ADDSUB: begin
				if (sum == 57'd0) begin
					res_q <= 64'd0;
				end else if (sum[56]) begin
					r_q <= {sum[56:2], sum[1] | sum[0]};
					e_q <= e_q + 13'sd1;
				end else begin
					r_q <= sum[55:0];
				end
			end
			F_POSTNORM: begin
				if (!r_q[55]) begin
					if (r_q[55:40] == 16'd0) begin
						r_q <= r_q << 16;
						e_q <= e_q - 13'sd16;
					end else begin
						r_q <= r_q << 1;
						e_q <= e_q - 13'sd1;
					end
				end
			end
			F_MUL: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q != 6'd4) begin
					prod_q <= mul_ah * mul_bh;
					psh_q  <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
				end
				if (cnt_q != 6'd0) begin
					acc_q <= acc_next;
				end
				if (cnt_q == 6'd4) begin
					if (acc_next[105]) begin
						r_q <= {acc_next[105:51], |acc_next[50:0]};
						e_q <= e_q + 13'sd1;
					end else begin
						r_q <= {acc_next[104:50], |acc_next[49:0]};
					end
				end
			end
			F_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (cnt_q == 6'd54) begin
					r_q <= {quo_next, |rem_next};
				end
			end
			F_RND_SHIFT: begin
				if (e_q < EMIN) begin
					r_q   <= {dn_wide[119:65], dn_wide[64] | (|dn_wide[63:0])};
					den_q <= 1'b1;
				end else begin
					den_q <= 1'b0;
				end
			end
			F_RND_PACK: begin
				res_q <= packed_res;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = (state_q == F_DONE);
	assign rsp.result = res_q;

endmodule

`default_nettype wire

>>> src/smfe_back.sv
// Back end: value stack, command sequencing and the result register.
`default_nettype none

module smfe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  smfe_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output smfe_pkg::fpu_req_t fpu_req,
	output logic [63:0]        fpu_a,
	output logic [63:0]        fpu_b,
	input  smfe_pkg::fpu_rsp_t fpu_rsp,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         result_kind,
	output logic [63:0]        number_bits,
	output logic [7:0]         message_out,
	output logic [7:0]         fault_opcode,
	output logic [10:0]        stack_depth
);
	import smfe_pkg::*;

	back_state_t       state_q, state_d;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic              halted_q, halted_d;
	logic              pop_ok_q, pop_ok_d;
	fop_t              fop_q, fop_d;
	logic [63:0]       opa_q, opb_q;
	logic              cap_a, cap_b;

	logic [63:0]       mem [STACK_DEPTH];
	logic [63:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [63:0]       wr_data;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [63:0]       num_q;
	logic [7:0]        msg_q;
	logic [7:0]        fop_out_q;
	logic [SP_W-1:0]   depth_q;

	logic              slot_free;
	logic              out_load;
	kind_t             ld_kind;
	logic [63:0]       ld_num;
	logic [7:0]        ld_msg;
	logic [7:0]        ld_fop;
	logic              sp_full;

	assign slot_free = !out_valid_q || !out_stall;
	assign sp_full   = (sp_q == SP_W'(STACK_DEPTH));
	assign rd_addr   = ADDR_W'(sp_q - SP_W'(1));

	always_comb begin
		state_d     = state_q;
		sp_d        = sp_q;
		halted_d    = halted_q;
		pop_ok_d    = pop_ok_q;
		fop_d       = fop_q;
		cmd_pop     = 1'b0;
		mem_we      = 1'b0;
		wr_data     = cmd.value;
		cap_a       = 1'b0;
		cap_b       = 1'b0;
		out_load    = 1'b0;
		ld_kind     = KIND_NONE;
		ld_num      = 64'd0;
		ld_msg      = 8'd0;
		ld_fop      = 8'd0;
		fpu_req.start = 1'b0;
		fpu_req.op    = fop_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid && slot_free) begin
					cmd_pop = 1'b1;
					if (halted_q) begin
						out_load = 1'b1;
						ld_kind  = KIND_IGNORED;
					end else begin
						case (cmd.cls)
							CLS_HALT: begin
								halted_d = 1'b1;
								out_load = 1'b1;
								ld_kind  = KIND_HALTED;
							end
							CLS_PUSH: begin
								if (!sp_full) begin
									mem_we = 1'b1;
									sp_d   = sp_q + SP_W'(1);
								end
								out_load = 1'b1;
							end
							CLS_PRINT_MSG: begin
								out_load = 1'b1;
								ld_kind  = KIND_MESSAGE;
								ld_msg   = cmd.msg;
							end
							CLS_PRINT_NUM: begin
								if (sp_q != '0) begin
									sp_d    = sp_q - SP_W'(1);
									state_d = B_PRINT_RD;
								end else begin
									out_load = 1'b1;
									ld_kind  = KIND_NUMBER;
								end
							end
							CLS_ARITH: begin
								fop_d    = cmd.fop;
								pop_ok_d = (sp_q != '0);
								if (sp_q != '0) begin
									sp_d = sp_q - SP_W'(1);
								end
								state_d = B_POP_A;
							end
							default: begin
								halted_d = 1'b1;
								out_load = 1'b1;
								ld_kind  = KIND_FAULT;
								ld_fop   = cmd.opcode;
							end
						endcase
					end
				end
			end
			B_PRINT_RD: begin
				out_load = 1'b1;
				ld_kind  = KIND_NUMBER;
				ld_num   = rd_data_q;
				state_d  = B_IDLE;
			end
			B_POP_A: begin
				cap_b    = 1'b1;
				pop_ok_d = (sp_q != '0);
				if (sp_q != '0) begin
					sp_d = sp_q - SP_W'(1);
				end
				state_d = B_CAP_A;
			end
			B_CAP_A: begin
				cap_a   = 1'b1;
				state_d = B_EXEC;
			end
			B_EXEC: begin
				fpu_req.start = 1'b1;
				state_d       = B_WAIT;
			end
			B_WAIT: begin
				if (fpu_rsp.done) begin
					wr_data = fpu_rsp.result;
					if (!sp_full) begin
						mem_we = 1'b1;
						sp_d   = sp_q + SP_W'(1);
					end
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[sp_q[ADDR_W-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cap_b) begin
			opb_q <= pop_ok_q ? rd_data_q : 64'd0;
		end
		if (cap_a) begin
			opa_q <= pop_ok_q ? rd_data_q : 64'd0;
		end
		fop_q <= fop_d;
		if (out_load) begin
			kind_q    <= ld_kind;
			num_q     <= ld_num;
			msg_q     <= ld_msg;
			fop_out_q <= ld_fop;
			depth_q   <= sp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sp_q        <= '0;
			halted_q    <= 1'b0;
			pop_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sp_q     <= sp_d;
			halted_q <= halted_d;
			pop_ok_q <= pop_ok_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign fpu_a        = opa_q;
	assign fpu_b        = opb_q;
	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign number_bits  = num_q;
	assign message_out  = msg_q;
	assign fault_opcode = fop_out_q;
	assign stack_depth  = 11'(depth_q);

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> (state_q == B_WAIT))
		else $error("arithmetic result arrived outside the wait state");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command queue popped while empty");

endmodule

`default_nettype wire

>>> src/stack_machine_fp_evaluator_core.sv
// Top level of the stack machine floating-point evaluator core.
// The core executes one decoded instruction per request against a stack of
// 1024 IEEE double values and returns exactly one result request for each.
// A front end decodes requests into a two-entry command queue, so the input
// side keeps accepting while the back end is busy or its result waits on a
// stalled output. Push, print-message, halt, fault and every request taken
// while halted finish in the back end's idle state; print-number goes on
// through a read state, since the stack memory has a registered read. Add
// and subtract normalize, align, add and round, multiply sums four 27x27
// partial products from one multiplier, and divide uses a restoring divider
// that makes one quotient bit per cycle. Operands that decide the result on
// their own, such as zeros, infinities and NaNs, skip the datapath, and an
// exact cancellation skips rounding. Subnormal operands or a large
// cancellation in a subtraction add normalization cycles, at most sixteen bit
// positions a cycle. Results round to nearest even; every NaN result is the
// canonical quiet NaN. A halt or unknown opcode stops execution until reset.
`default_nettype none

module stack_machine_fp_evaluator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  message_index,
	input  wire logic [63:0] constant_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_kind,
	output logic [63:0]      number_bits,
	output logic [7:0]       message_out,
	output logic [7:0]       fault_opcode,
	output logic [10:0]      stack_depth
);
	import smfe_pkg::*;

	logic        cmd_valid;
	cmd_t        cmd;
	logic        cmd_pop;
	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;
	logic [63:0] fpu_a;
	logic [63:0] fpu_b;

	// Decode and queue incoming requests.
	smfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.message_index (message_index),
		.constant_bits (constant_bits),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	// Shared arithmetic unit, started by the back end once both operands
	// have been popped.
	smfe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.a_bits (fpu_a),
		.b_bits (fpu_b),
		.rsp    (fpu_rsp)
	);

	// Stack, sequencing and the output register.
	smfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.fpu_req      (fpu_req),
		.fpu_a        (fpu_a),
		.fpu_b        (fpu_b),
		.fpu_rsp      (fpu_rsp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.number_bits  (number_bits),
		.message_out  (message_out),
		.fault_opcode (fault_opcode),
		.stack_depth  (stack_depth)
	);

endmodule

`default_nettype wire
